/* hdl/page_frame_allocator_core_assert.svh */
// ----------------------------------------------------------------------------
// assertion macros used by the allocator checker
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// condition in the same cycle
`define PFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfa check failed");

// condition in the next cycle
`define PFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfa check failed");

`endif

/* hdl/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// types and constants of the page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int unsigned CFG_W  = 17;
  localparam int unsigned REF_W  = 16;
  localparam int unsigned ZONE_COUNT = 3;

  localparam logic [CFG_W-1:0] ZONE0_TOP_RST = 17'd256;
  localparam logic [CFG_W-1:0] ZONE1_TOP_RST = 17'd65536;
  localparam logic [REF_W-1:0] REF_MAX = 16'hFFFF;

  // register indexes
  localparam logic REG_ZONE0_TOP = 1'b0;
  localparam logic REG_ZONE1_TOP = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_MISUSE = 2'd2;

  typedef enum logic [1:0] {
    FN_FREE    = 2'd0,
    FN_HOLD    = 2'd1,
    FN_RELEASE = 2'd2,
    FN_ALLOC   = 2'd3
  } pfa_func_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_FIXP_RD,
    S_FIXP_WR,
    S_FIXN_RD,
    S_FIXN_WR,
    S_NEXT,
    S_SCAN_Z,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } pfa_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] zone0_top;
    logic [CFG_W-1:0] zone1_top;
    logic             upd;
  } pfa_cfg_t;

endpackage

/* hdl/pfa_page_mem.sv */
// ----------------------------------------------------------------------------
// pfa_page_mem
// per-page state memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pfa_page_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 51
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pfa_apb.sv */
// ----------------------------------------------------------------------------
// pfa_apb
// zone boundary registers behind the apb port
// ----------------------------------------------------------------------------
module pfa_apb (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output pfa_pkg::pfa_cfg_t     cfg
);

  logic [pfa_pkg::CFG_W-1:0] zone0_top_r, zone0_top_nxt;
  logic [pfa_pkg::CFG_W-1:0] zone1_top_r, zone1_top_nxt;
  logic                      upd_r, upd_nxt;
  logic                      wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // register write decode
  always_comb begin
    zone0_top_nxt = zone0_top_r;
    zone1_top_nxt = zone1_top_r;
    upd_nxt       = wr;
    if (wr) begin
      unique case (paddr[2])
        pfa_pkg::REG_ZONE0_TOP: zone0_top_nxt = pwdata[pfa_pkg::CFG_W-1:0];
        pfa_pkg::REG_ZONE1_TOP: zone1_top_nxt = pwdata[pfa_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone0_top_r <= pfa_pkg::ZONE0_TOP_RST;
      zone1_top_r <= pfa_pkg::ZONE1_TOP_RST;
      upd_r       <= 1'b0;
    end else begin
      zone0_top_r <= zone0_top_nxt;
      zone1_top_r <= zone1_top_nxt;
      upd_r       <= upd_nxt;
    end
  end

  // read back
  assign prdata = (paddr[2] == pfa_pkg::REG_ZONE1_TOP) ? 32'(zone1_top_r) : 32'(zone0_top_r);

  assign cfg.zone0_top = zone0_top_r;
  assign cfg.zone1_top = zone1_top_r;
  assign cfg.upd       = upd_r;

endmodule

/* hdl/pfa_seq.sv */
// ----------------------------------------------------------------------------
// pfa_seq
// request sequencer: read-modify-write of page state, free lists and scans
// ----------------------------------------------------------------------------
module pfa_seq #(
  parameter int unsigned N_PAGES = 65536,
  parameter int unsigned PW = 16,
  parameter int unsigned DW = 51
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pfa_pkg::pfa_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [15:0]       in_page_id,
  input  logic [16:0]       in_count,
  input  logic [1:0]        in_zone,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [15:0]       out_base_page,
  output logic [16:0]       out_free_cnt,
  output logic [16:0]       out_handed_cnt,
  output logic              mem_we,
  output logic [PW-1:0]     mem_waddr,
  output logic [DW-1:0]     mem_wdata,
  output logic [PW-1:0]     mem_raddr,
  input  logic [DW-1:0]     mem_rdata
);

  localparam int unsigned LW = PW + 1;
  localparam int unsigned IW = (LW > 18) ? LW : 18;
  localparam int unsigned RW = pfa_pkg::REF_W;
  localparam logic [LW-1:0] NIL  = LW'(N_PAGES);
  localparam logic [IW-1:0] PC_I = IW'(N_PAGES);
  localparam logic [PW-1:0] LAST = PW'(N_PAGES - 1);

  pfa_pkg::pfa_state_t state_r, state_nxt;
  pfa_pkg::pfa_func_t  func_r, func_nxt;
  logic [16:0]   cnt_r, cnt_nxt, rem_r, rem_nxt, found_r, found_nxt;
  logic [1:0]    zone_r, zone_nxt, status_r, status_nxt;
  logic [IW-1:0] id_r, id_nxt, base_r, base_nxt;
  logic [LW-1:0] scan_r, scan_nxt, top_r, top_nxt;
  logic [LW-1:0] p_r, p_nxt, n_r, n_nxt, pv_r, pv_nxt;
  logic [LW-1:0] head_r [3];
  logic [LW-1:0] head_nxt [3];
  logic [LW-1:0] start_r [3];
  logic [LW-1:0] start_nxt [3];
  logic [LW-1:0] free_r, free_nxt;
  logic [16:0]   handed_r, handed_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [15:0]   out_base_r, out_base_nxt;
  logic [16:0]   out_free_r, out_free_nxt, out_total_r, out_total_nxt;

  // word fields of the page memory: mark, count, next, prev
  logic          w_mark;
  logic [RW-1:0] w_ref;
  logic [LW-1:0] w_next, w_prev, id_l, zb1, zb2;
  logic [1:0]    zi, zc;
  logic          ins;
  logic [17:0]   hsum;
  logic [16:0]   f_cnt;

  assign w_mark = mem_rdata[DW-1];
  assign w_ref  = mem_rdata[DW-2 -: RW];
  assign w_next = mem_rdata[2*LW-1:LW];
  assign w_prev = mem_rdata[LW-1:0];
  assign id_l   = id_r[LW-1:0];

  function automatic logic [LW-1:0] clampv(input logic [pfa_pkg::CFG_W-1:0] v);
    logic [LW-1:0] r;
    r = (IW'(v) > PC_I) ? NIL : LW'(v);
    return r;
  endfunction

  assign zb1 = clampv(cfg.zone0_top);
  assign zb2 = clampv(cfg.zone1_top);

  // zone a listed page belongs to
  always_comb begin
    if (IW'(id_l) < IW'(cfg.zone0_top))      zi = 2'd0;
    else if (IW'(id_l) < IW'(cfg.zone1_top)) zi = 2'd1;
    else                                      zi = 2'd2;
  end

  assign zc   = (in_zone == 2'd3) ? 2'd2 : in_zone;
  assign hsum = {1'b0, handed_r} + {1'b0, in_count};
  assign f_cnt = w_mark ? found_r + 17'd1 : 17'd0;

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    found_nxt  = found_r;
    zone_nxt   = zone_r;
    status_nxt = status_r;
    id_nxt     = id_r;
    base_nxt   = base_r;
    scan_nxt   = scan_r;
    top_nxt    = top_r;
    p_nxt      = p_r;
    n_nxt      = n_r;
    pv_nxt     = pv_r;
    head_nxt   = head_r;
    start_nxt  = start_r;
    free_nxt   = free_r;
    handed_nxt = handed_r;
    clr_nxt    = clr_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_base_nxt   = out_base_r;
    out_free_nxt   = out_free_r;
    out_total_nxt  = out_total_r;
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = id_r[PW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = id_r[PW-1:0];
    ins       = 1'b0;

    // boundary write resets the search starts
    if (cfg.upd) begin
      start_nxt[0] = '0;
      start_nxt[1] = zb1;
      start_nxt[2] = zb2;
    end

    unique case (state_r)
      // clearing pass after reset
      pfa_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + PW'(1);
        if (clr_r == LAST) state_nxt = pfa_pkg::S_IDLE;
      end

      pfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt   = pfa_pkg::pfa_func_t'(in_func);
          cnt_nxt    = in_count;
          rem_nxt    = in_count;
          zone_nxt   = zc;
          status_nxt = pfa_pkg::ST_OK;
          id_nxt     = IW'(in_page_id);
          base_nxt   = '0;
          found_nxt  = '0;
          unique case (pfa_pkg::pfa_func_t'(in_func))
            pfa_pkg::FN_FREE: begin
              handed_nxt = hsum[17] ? 17'h1FFFF : hsum[16:0];
              state_nxt  = (in_count == '0) ? pfa_pkg::S_DONE : pfa_pkg::S_RD;
            end
            pfa_pkg::FN_RELEASE: begin
              state_nxt = (in_count == '0) ? pfa_pkg::S_DONE : pfa_pkg::S_RD;
            end
            pfa_pkg::FN_HOLD: begin
              rem_nxt   = 17'd1;
              state_nxt = pfa_pkg::S_RD;
            end
            pfa_pkg::FN_ALLOC: begin
              if (in_count == '0) begin
                status_nxt = pfa_pkg::ST_NONE;
                state_nxt  = pfa_pkg::S_DONE;
              end else if (in_count == 17'd1) begin
                // single page: pop the first non-empty list head
                state_nxt = pfa_pkg::S_RD;
                priority if (zc == 2'd2 && head_r[2] != NIL) id_nxt = IW'(head_r[2]);
                else if (zc != 2'd0 && head_r[1] != NIL)     id_nxt = IW'(head_r[1]);
                else if (head_r[0] != NIL)                    id_nxt = IW'(head_r[0]);
                else begin
                  status_nxt = pfa_pkg::ST_NONE;
                  state_nxt  = pfa_pkg::S_DONE;
                end
                base_nxt = id_nxt;
              end else begin
                state_nxt = pfa_pkg::S_SCAN_Z;
              end
            end
            default: ;
          endcase
        end
      end

      // issue the page read
      pfa_pkg::S_RD: begin
        if (id_r >= PC_I) begin
          status_nxt = pfa_pkg::ST_MISUSE;
          state_nxt  = pfa_pkg::S_DONE;
        end else begin
          state_nxt = pfa_pkg::S_CHK;
        end
      end

      // modify and write back the page
      pfa_pkg::S_CHK: begin
        state_nxt = pfa_pkg::S_NEXT;
        unique case (func_r)
          pfa_pkg::FN_FREE: begin
            if (w_mark) status_nxt = pfa_pkg::ST_MISUSE;
            else        ins = 1'b1;
          end
          pfa_pkg::FN_HOLD: begin
            state_nxt = pfa_pkg::S_DONE;
            if (w_mark || w_ref == pfa_pkg::REF_MAX) begin
              status_nxt = pfa_pkg::ST_MISUSE;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {w_mark, w_ref + RW'(1), w_next, w_prev};
            end
          end
          pfa_pkg::FN_RELEASE: begin
            if (w_ref == '0) begin
              status_nxt = pfa_pkg::ST_MISUSE;
            end else if (w_ref == RW'(1)) begin
              ins = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {w_mark, w_ref - RW'(1), w_next, w_prev};
            end
          end
          pfa_pkg::FN_ALLOC: begin
            // take the page off its list
            mem_we    = 1'b1;
            mem_wdata = {1'b0, RW'(1), NIL, NIL};
            if (free_r != '0) free_nxt = free_r - LW'(1);
            p_nxt  = w_prev;
            n_nxt  = w_next;
            pv_nxt = w_prev;
            if (w_prev != NIL) begin
              state_nxt = pfa_pkg::S_FIXP_RD;
            end else begin
              for (int z = 0; z < 3; z++) begin
                if (head_r[z] == id_l) head_nxt[z] = w_next;
              end
              if (w_next != NIL) state_nxt = pfa_pkg::S_FIXN_RD;
            end
          end
          default: ;
        endcase
        // push at the head of the zone's list
        if (ins) begin
          mem_we       = 1'b1;
          mem_wdata    = {1'b1, RW'(0), head_r[zi], NIL};
          head_nxt[zi] = id_l;
          if (start_r[zi] > id_l) start_nxt[zi] = id_l;
          free_nxt = free_r + LW'(1);
          n_nxt    = head_r[zi];
          pv_nxt   = id_l;
          if (head_r[zi] != NIL) state_nxt = pfa_pkg::S_FIXN_RD;
        end
      end

      // relink the predecessor
      pfa_pkg::S_FIXP_RD: begin
        mem_raddr = p_r[PW-1:0];
        state_nxt = pfa_pkg::S_FIXP_WR;
      end
      pfa_pkg::S_FIXP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = p_r[PW-1:0];
        mem_wdata = {w_mark, w_ref, n_r, w_prev};
        state_nxt = (n_r != NIL) ? pfa_pkg::S_FIXN_RD : pfa_pkg::S_NEXT;
      end

      // relink the successor
      pfa_pkg::S_FIXN_RD: begin
        mem_raddr = n_r[PW-1:0];
        state_nxt = pfa_pkg::S_FIXN_WR;
      end
      pfa_pkg::S_FIXN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = n_r[PW-1:0];
        mem_wdata = {w_mark, w_ref, w_next, pv_r};
        state_nxt = pfa_pkg::S_NEXT;
      end

      // step along the run
      pfa_pkg::S_NEXT: begin
        if (rem_r == 17'd1) begin
          state_nxt = pfa_pkg::S_DONE;
        end else begin
          rem_nxt   = rem_r - 17'd1;
          id_nxt    = id_r + IW'(1);
          state_nxt = pfa_pkg::S_RD;
        end
      end

      // contiguous scan, one zone at a time
      pfa_pkg::S_SCAN_Z: begin
        found_nxt = '0;
        unique case (zone_r)
          2'd0: begin scan_nxt = start_r[0]; top_nxt = zb1; end
          2'd1: begin scan_nxt = start_r[1]; top_nxt = zb2; end
          default: begin scan_nxt = start_r[2]; top_nxt = NIL; end
        endcase
        state_nxt = pfa_pkg::S_SCAN_RD;
      end
      pfa_pkg::S_SCAN_RD: begin
        mem_raddr = scan_r[PW-1:0];
        if (scan_r >= top_r) begin
          if (zone_r == 2'd0) begin
            status_nxt = pfa_pkg::ST_NONE;
            state_nxt  = pfa_pkg::S_DONE;
          end else begin
            zone_nxt  = zone_r - 2'd1;
            state_nxt = pfa_pkg::S_SCAN_Z;
          end
        end else begin
          state_nxt = pfa_pkg::S_SCAN_CHK;
        end
      end
      pfa_pkg::S_SCAN_CHK: begin
        if (f_cnt == cnt_r) begin
          base_nxt  = IW'(scan_r) - IW'(cnt_r - 17'd1);
          id_nxt    = base_nxt;
          rem_nxt   = cnt_r;
          state_nxt = pfa_pkg::S_RD;
        end else begin
          found_nxt = f_cnt;
          scan_nxt  = scan_r + LW'(1);
          state_nxt = pfa_pkg::S_SCAN_RD;
        end
      end

      // hand the result to the output register
      pfa_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_base_nxt   = (func_r == pfa_pkg::FN_ALLOC && status_r == pfa_pkg::ST_OK) ?
                           base_r[15:0] : 16'd0;
          out_free_nxt   = 17'(free_r);
          out_total_nxt  = handed_r;
          state_nxt      = pfa_pkg::S_IDLE;
        end
      end

      default: state_nxt = pfa_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfa_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      free_r      <= '0;
      handed_r    <= '0;
      head_r[0]   <= NIL;
      head_r[1]   <= NIL;
      head_r[2]   <= NIL;
      start_r[0]  <= '0;
      start_r[1]  <= clampv(pfa_pkg::ZONE0_TOP_RST);
      start_r[2]  <= clampv(pfa_pkg::ZONE1_TOP_RST);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      free_r      <= free_nxt;
      handed_r    <= handed_nxt;
      head_r      <= head_nxt;
      start_r     <= start_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    cnt_r        <= cnt_nxt;
    rem_r        <= rem_nxt;
    found_r      <= found_nxt;
    zone_r       <= zone_nxt;
    status_r     <= status_nxt;
    id_r         <= id_nxt;
    base_r       <= base_nxt;
    scan_r       <= scan_nxt;
    top_r        <= top_nxt;
    p_r          <= p_nxt;
    n_r          <= n_nxt;
    pv_r         <= pv_nxt;
    out_status_r <= out_status_nxt;
    out_base_r   <= out_base_nxt;
    out_free_r   <= out_free_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_base_page  = out_base_r;
  assign out_free_cnt   = out_free_r;
  assign out_handed_cnt = out_total_r;

endmodule

/* hdl/page_frame_allocator_core.sv */
// Each request runs through the sequencer states from input transfer to result valid; a
// multi-page allocate first scans its zones for a contiguous run, then takes each page of it.
// One item at a time, set by the request sequencer: the next input transfer comes in the cycle
// after the result is registered at the earliest.
// Reset: synchronous, active low; then a clearing pass over every page with no input transfer.
// ----------------------------------------------------------------------------
// page_frame_allocator_core
// zoned free-list page frame allocator, top level
// ----------------------------------------------------------------------------
module page_frame_allocator_core #(
  parameter int unsigned N_PAGES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_page_id,
  input  logic [16:0] in_count,
  input  logic [1:0]  in_zone,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_base_page,
  output logic [16:0] out_free_cnt,
  output logic [16:0] out_handed_cnt
);

  localparam int unsigned PW = $clog2(N_PAGES);
  localparam int unsigned DW = 1 + pfa_pkg::REF_W + 2 * (PW + 1);

  pfa_pkg::pfa_cfg_t cfg;
  logic          mem_we;
  logic [PW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  // configuration registers
  pfa_apb u_apb (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  // request sequencer
  pfa_seq #(.N_PAGES(N_PAGES), .PW(PW), .DW(DW)) u_seq (
    .clk, .rst_n, .cfg,
    .in_valid, .in_ready, .in_func, .in_page_id, .in_count, .in_zone,
    .out_valid, .out_ready, .out_status, .out_base_page, .out_free_cnt,
    .out_handed_cnt,
    .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  // page state memory
  pfa_page_mem #(.DEPTH(N_PAGES), .AW(PW), .DW(DW)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

endmodule

/* hdl/pfa_checker.sv */
// ----------------------------------------------------------------------------
// pfa_checker
// port level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "page_frame_allocator_core_assert.svh"

module pfa_checker #(
  parameter int unsigned N_PAGES = 65536
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_base_page,
  input logic [16:0] out_free_cnt
);

  // one item at a time: no transfer right after a transfer
  `PFA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

  // failed requests report no base page
  `PFA_ASSERT_NOW(a_base_zero, out_valid && out_status != pfa_pkg::ST_OK, out_base_page == 16'd0)

  // free page count never exceeds the pool
  `PFA_ASSERT_NOW(a_free_bound, out_valid, 32'(out_free_cnt) <= N_PAGES)

  // a waiting result holds until taken
  `PFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status))

endmodule

bind page_frame_allocator_core pfa_checker #(.N_PAGES(N_PAGES)) u_pfa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_base_page(out_base_page), .out_free_cnt(out_free_cnt)
);
